// ===== rtl/smsdp_pkg.sv =====
// Shared types and constants for the SMS-DELIVER PDU parser.
package smsdp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_SENDER  = 3'd0;
    localparam logic [2:0] KIND_PID     = 3'd1;
    localparam logic [2:0] KIND_DCS     = 3'd2;
    localparam logic [2:0] KIND_STAMP   = 3'd3;
    localparam logic [2:0] KIND_MSG     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Coding schemes (low nibble of the coding scheme octet)
    localparam logic [3:0] MODE_GSM7    = 4'd0;
    localparam logic [3:0] MODE_8BIT    = 4'd4;
    localparam logic [3:0] MODE_UCS2    = 4'd8;

    // Character and field constants
    localparam logic [7:0]  ALPHA_MASK  = 8'hD0;
    localparam logic [3:0]  BCD_FILLER  = 4'hF;
    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_PLUS   = 8'd43;
    localparam logic [15:0] CHAR_SPACE  = 16'd32;
    localparam logic [6:0]  CHAR_DEL    = 7'd127;
    localparam logic [6:0]  GSM_CTRL_LIM = 7'd32;
    localparam logic [15:0] NARROW_LO   = 16'd20;
    localparam logic [15:0] NARROW_HI   = 16'd125;
    localparam logic [2:0]  STAMP_LAST  = 3'd6;

    // One result request
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [2:0]  idx;
        logic        done;
        logic        last;
    } t_result;

    // Results of one decoded octet: up to two, slot 0 first
    typedef struct packed {
        t_result     r0;
        t_result     r1;
        logic [1:0]  cnt;
    } t_dec_out;

endpackage

// ===== rtl/smsdp_decode.sv =====
// PDU walker: parse state and the per-octet decode logic.
module smsdp_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_octet,
    input  logic                  i_start,
    input  logic                  i_wide,
    output smsdp_pkg::t_dec_out   o_dec
);
    import smsdp_pkg::*;

    typedef enum logic [11:0] {
        PH_SCA_LEN  = 12'h001,
        PH_SCA_SKIP = 12'h002,
        PH_FIRST    = 12'h004,
        PH_SND_LEN  = 12'h008,
        PH_SND_TYPE = 12'h010,
        PH_SND_ADDR = 12'h020,
        PH_PID      = 12'h040,
        PH_DCS      = 12'h080,
        PH_STAMP    = 12'h100,
        PH_UD_LEN   = 12'h200,
        PH_UD       = 12'h400,
        PH_IDLE     = 12'h800
    } t_phase;

    // GSM control codes show up as DEL
    function automatic logic [6:0] fix7(input logic [6:0] c);
        fix7 = (c < GSM_CTRL_LIM) ? CHAR_DEL : c;
    endfunction

    t_phase      r_phase, n_phase, ph;
    logic [7:0]  r_field, n_field;
    logic [2:0]  r_off, n_off;
    logic [6:0]  r_left, n_left;
    logic [7:0]  r_chars, n_chars;
    logic        r_alpha, n_alpha;
    logic        r_first, n_first;
    logic [3:0]  r_mode, n_mode;
    logic [7:0]  r_hbyte, n_hbyte;
    logic        r_hpend, n_hpend;
    logic [2:0]  r_stamp, n_stamp;

    // septet unpacker outputs
    logic [13:0] sep_sh;
    logic [6:0]  sep_c, sep_lo;
    logic [2:0]  sep_kind;
    logic        sep_msg;
    t_result     sep_r0, sep_r1;
    logic [1:0]  sep_cnt;
    logic [7:0]  sep_chars;
    logic [2:0]  sep_off;
    logic [6:0]  sep_left;

    t_result     res0, res1;
    logic [1:0]  cnt;
    logic [7:0]  snd_oct;
    logic [7:0]  stamp_val;
    logic [7:0]  field_dec;
    logic [15:0] code;
    logic        have;

    assign ph = i_start ? PH_SCA_LEN : r_phase;

    // Septet unpacking: one octet yields up to two 7-bit characters
    always_comb begin
        sep_sh    = {6'd0, i_octet} << r_off;
        sep_c     = sep_sh[6:0] | r_left;
        sep_lo    = sep_sh[13:7];
        sep_msg   = (ph == PH_UD);
        sep_kind  = sep_msg ? KIND_MSG : KIND_SENDER;
        sep_r0    = '0;
        sep_r1    = '0;
        sep_cnt   = 2'd0;
        sep_chars = r_chars;
        sep_off   = r_off + 3'd1;
        sep_left  = sep_lo;
        if (r_chars != 8'd0) begin
            sep_r0.kind  = sep_kind;
            sep_r0.value = {9'd0, fix7(sep_c)};
            sep_r0.done  = sep_msg && (r_chars == 8'd1);
            sep_cnt      = 2'd1;
            sep_chars    = r_chars - 8'd1;
        end
        if (r_off == 3'd6) begin
            if (r_chars >= 8'd2) begin
                sep_r1.kind  = sep_kind;
                sep_r1.value = {9'd0, fix7(sep_lo)};
                sep_r1.done  = sep_msg && (r_chars == 8'd2);
                sep_cnt      = 2'd2;
                sep_chars    = r_chars - 8'd2;
            end
            sep_off  = 3'd0;
            sep_left = 7'd0;
        end
    end

    // Per-octet parse step
    always_comb begin
        n_phase   = ph;
        n_field   = r_field;
        n_off     = r_off;
        n_left    = r_left;
        n_chars   = r_chars;
        n_alpha   = r_alpha;
        n_first   = r_first;
        n_mode    = r_mode;
        n_hbyte   = r_hbyte;
        n_hpend   = r_hpend;
        n_stamp   = r_stamp;
        res0      = '0;
        res1      = '0;
        cnt       = 2'd0;
        // octet count of the sender digits, rounded up
        snd_oct   = {1'b0, i_octet[7:1]} + {7'd0, i_octet[0]};
        stamp_val = {1'b0, i_octet[3:0], 3'd0} + {3'd0, i_octet[3:0], 1'b0}
                    + {4'd0, i_octet[7:4]};
        field_dec = r_field - 8'd1;
        code      = '0;
        have      = 1'b0;

        case (ph)
            PH_SCA_LEN: begin
                n_field = i_octet;
                n_phase = (i_octet == 8'd0) ? PH_FIRST : PH_SCA_SKIP;
            end
            PH_SCA_SKIP: begin
                n_field = field_dec;
                if (field_dec == 8'd0) n_phase = PH_FIRST;
            end
            PH_FIRST: begin
                n_phase = PH_SND_LEN;
            end
            PH_SND_LEN: begin
                n_field = snd_oct;
                n_chars = snd_oct;
                n_first = 1'b1;
                n_phase = PH_SND_TYPE;
            end
            PH_SND_TYPE: begin
                n_alpha = ((i_octet & ALPHA_MASK) == ALPHA_MASK);
                n_off   = 3'd0;
                n_left  = 7'd0;
                if (!n_alpha && r_first) begin
                    res0.kind  = KIND_SENDER;
                    res0.value = {8'd0, CHAR_PLUS};
                    cnt        = 2'd1;
                end
                n_first = 1'b0;
                n_phase = (r_field == 8'd0) ? PH_PID : PH_SND_ADDR;
            end
            PH_SND_ADDR: begin
                if (r_alpha) begin
                    res0    = sep_r0;
                    res1    = sep_r1;
                    cnt     = sep_cnt;
                    n_chars = sep_chars;
                    n_off   = sep_off;
                    n_left  = sep_left;
                end else begin
                    // swapped BCD: low nibble first, filler high nibble dropped
                    res0.kind  = KIND_SENDER;
                    res0.value = {8'd0, {4'd0, i_octet[3:0]} + CHAR_ZERO};
                    cnt        = 2'd1;
                    if (i_octet[7:4] != BCD_FILLER) begin
                        res1.kind  = KIND_SENDER;
                        res1.value = {8'd0, {4'd0, i_octet[7:4]} + CHAR_ZERO};
                        cnt        = 2'd2;
                    end
                end
                n_field = field_dec;
                if (field_dec == 8'd0) n_phase = PH_PID;
            end
            PH_PID: begin
                res0.kind  = KIND_PID;
                res0.value = {8'd0, i_octet};
                cnt        = 2'd1;
                n_phase    = PH_DCS;
            end
            PH_DCS: begin
                res0.kind  = KIND_DCS;
                res0.value = {8'd0, i_octet};
                cnt        = 2'd1;
                n_mode     = i_octet[3:0];
                n_stamp    = 3'd0;
                n_phase    = PH_STAMP;
            end
            PH_STAMP: begin
                res0.kind  = KIND_STAMP;
                res0.value = {8'd0, stamp_val};
                res0.idx   = r_stamp;
                cnt        = 2'd1;
                if (r_stamp >= STAMP_LAST) begin
                    n_stamp = 3'd0;
                    n_phase = PH_UD_LEN;
                end else begin
                    n_stamp = r_stamp + 3'd1;
                end
            end
            PH_UD_LEN: begin
                n_off   = 3'd0;
                n_left  = 7'd0;
                n_hpend = 1'b0;
                if (r_mode == MODE_GSM7) begin
                    n_chars = i_octet;
                    n_phase = (i_octet == 8'd0) ? PH_IDLE : PH_UD;
                end else if (r_mode == MODE_8BIT || r_mode == MODE_UCS2) begin
                    n_field = i_octet;
                    n_phase = (i_octet == 8'd0) ? PH_IDLE : PH_UD;
                end else begin
                    res0.kind  = KIND_ERROR;
                    res0.value = {12'd0, r_mode};
                    res0.done  = 1'b1;
                    cnt        = 2'd1;
                    n_phase    = PH_IDLE;
                end
            end
            PH_UD: begin
                if (r_mode == MODE_GSM7) begin
                    res0    = sep_r0;
                    res1    = sep_r1;
                    cnt     = sep_cnt;
                    n_chars = sep_chars;
                    n_off   = sep_off;
                    n_left  = sep_left;
                    if (sep_chars == 8'd0) n_phase = PH_IDLE;
                end else if (r_mode == MODE_8BIT) begin
                    n_field    = field_dec;
                    res0.kind  = KIND_MSG;
                    res0.value = {8'd0, i_octet};
                    res0.done  = (field_dec == 8'd0);
                    cnt        = 2'd1;
                    if (field_dec == 8'd0) n_phase = PH_IDLE;
                end else begin
                    // UCS-2: high byte first; a lone final octet gets low byte zero
                    n_field = field_dec;
                    if (!r_hpend) begin
                        n_hbyte = i_octet;
                        n_hpend = 1'b1;
                        if (field_dec == 8'd0) begin
                            code = {i_octet, 8'd0};
                            have = 1'b1;
                        end
                    end else begin
                        code    = {r_hbyte, i_octet};
                        n_hpend = 1'b0;
                        have    = 1'b1;
                    end
                    if (have) begin
                        if (!i_wide && (code < NARROW_LO || code > NARROW_HI))
                            code = CHAR_SPACE;
                        res0.kind  = KIND_MSG;
                        res0.value = code;
                        res0.done  = (field_dec == 8'd0);
                        cnt        = 2'd1;
                    end
                    if (field_dec == 8'd0) begin
                        n_hpend = 1'b0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // mark the final result of this octet
        if (cnt == 2'd1) res0.last = 1'b1;
        if (cnt == 2'd2) res1.last = 1'b1;
    end

    assign o_dec.r0  = res0;
    assign o_dec.r1  = res1;
    assign o_dec.cnt = cnt;

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCA_LEN;
            r_field <= 8'd0;
            r_off   <= 3'd0;
            r_left  <= 7'd0;
            r_chars <= 8'd0;
            r_alpha <= 1'b0;
            r_first <= 1'b1;
            r_mode  <= 4'd0;
            r_hbyte <= 8'd0;
            r_hpend <= 1'b0;
            r_stamp <= 3'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_off   <= n_off;
            r_left  <= n_left;
            r_chars <= n_chars;
            r_alpha <= n_alpha;
            r_first <= n_first;
            r_mode  <= n_mode;
            r_hbyte <= n_hbyte;
            r_hpend <= n_hpend;
            r_stamp <= n_stamp;
        end
    end

endmodule

// ===== rtl/sms_deliver_pdu_parser.sv =====
// SMS-DELIVER PDU parser: input register, decode step and two-slot result register.
// Path: an accepted request waits in the input register until the result register can
//   take its results; the decode step is combinational and its results are registered.
// Throughput: one octet per cycle while the receiver keeps up; an octet with two results
//   holds the decode step until its second result is taken.
// Reset: synchronous, active low; parse restarts, wide_chars 0, all registers empty.
module sms_deliver_pdu_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input octet stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pdu_octet
    input  logic        s_axis_tuser,   // [0] pdu_start
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] item_value, [18:16] stamp_index,
                                        // [19] message_done, [23:20] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] item_kind
    output logic        m_axis_tlast,   // last_of_run
    // configuration write: wide_chars
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import smsdp_pkg::*;

    logic       r_wide;
    logic       r_in_valid;
    logic [7:0] r_in_octet;
    logic       r_in_start;
    t_result    r_res0, r_res1;
    logic [1:0] r_cnt;
    logic       r_head;

    t_dec_out   dec;
    t_result    cur;
    logic       can_load, advance, m_fire, s_fire;

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (i_cfg_valid) begin
            r_wide <= i_cfg_data;
        end
    end

    // Handshake control
    assign m_fire        = (r_cnt != 2'd0) && m_axis_tready;
    assign can_load      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign advance       = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_octet <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    smsdp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_octet (r_in_octet),
        .i_start (r_in_start),
        .i_wide  (r_wide),
        .o_dec   (dec)
    );

    // Result register: up to two results, drained in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else if (advance) begin
            r_cnt  <= dec.cnt;
            r_head <= 1'b0;
        end else if (m_fire) begin
            if (r_cnt == 2'd2) begin
                r_cnt  <= 2'd1;
                r_head <= 1'b1;
            end else begin
                r_cnt  <= 2'd0;
                r_head <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res0 <= dec.r0;
            r_res1 <= dec.r1;
        end
    end

    // Output mapping
    assign cur           = r_head ? r_res1 : r_res0;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {4'd0, cur.done, cur.idx, cur.value};
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = cur.last;

`ifndef ASSERT_OFF
    // second slot is only ever presented alone
    a_head_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head |-> (r_cnt == 2'd1))
        else $error("second result slot presented with count not one");

    // a pair never has its first result marked last
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_res0.last)
        else $error("first of two results marked last");

    // end of message is always the last result of its octet
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[19]) |-> m_axis_tlast)
        else $error("message end not on last result of octet");
`endif

endmodule

// ===== bench/sms_deliver_pdu_parser_tb.sv =====
// Self-checking bench for the SMS-DELIVER PDU parser: octet stream in, decoded items out.
`timescale 1ns / 1ps

module sms_deliver_pdu_parser_tb;
    import smsdp_pkg::*;

    localparam int IDLE_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int LONG_HOLD   = 100;   // receiver hold-off, long enough to back up the input
    localparam int LATENCY_PAD = 8;     // settle time for octets that produce nothing
    localparam int MAX_REPORTS = 40;

    // Parser position inside the PDU
    typedef enum logic [3:0] {
        ST_SC_LEN, ST_SC_SKIP, ST_FIRST, ST_ADDR_LEN, ST_ADDR_TYPE, ST_ADDR_DIGITS,
        ST_PID, ST_DCS, ST_STAMP, ST_UD_LEN, ST_UD, ST_IGNORE
    } t_parse_state;

    // One octet request for the input stream
    typedef struct packed {
        logic [7:0] octet;
        logic       start;
    } t_octet_req;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;  // [7:0] pdu_octet
    logic        s_axis_tuser  = 1'b0;  // [0] pdu_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] item_value, [18:16] stamp_index,
                                        // [19] message_done, [23:20] zero
    logic [2:0]  m_axis_tuser;          // [2:0] item_kind
    logic        m_axis_tlast;          // last_of_run
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;

    sms_deliver_pdu_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Stimulus and expectation stores
    t_octet_req octet_q[$];
    t_result    due_results[$];
    int         stim_count  = 0;
    int         pdu_serial  = 0;
    int         mismatches  = 0;
    int         rx_count    = 0;
    int         idle_cycles = 0;
    int         send_gap    = 0;
    int         rx_wait     = 0;
    int         long_mark   = 100;
    bit         no_idle     = 1'b0;
    bit         in_fire     = 1'b0;
    bit         out_fire    = 1'b0;
    t_octet_req cur_req;
    t_result    want;

    // Decoder shadow state
    t_parse_state ps;
    logic [7:0]   left_cnt;
    logic [2:0]   sep_off;
    logic [6:0]   sep_carry;
    logic [7:0]   chars_to_go;
    logic         alpha_addr;
    logic         addr_first;
    logic [3:0]   scheme;
    logic [7:0]   ucs_hi;
    logic         ucs_hi_valid;
    logic [2:0]   stamp_pos;
    logic         wide_mode;
    t_result      step_buf[3];
    int           step_n;

    function automatic logic [15:0] gsm_char(input logic [6:0] c);
        return (c < GSM_CTRL_LIM) ? {9'd0, CHAR_DEL} : {9'd0, c};
    endfunction

    task automatic add_result(input logic [2:0] kind, input logic [15:0] value,
                              input logic [2:0] idx, input logic done);
        step_buf[step_n].kind  = kind;
        step_buf[step_n].value = value;
        step_buf[step_n].idx   = idx;
        step_buf[step_n].done  = done;
        step_buf[step_n].last  = 1'b0;
        step_n++;
    endtask

    // Unpack 7-bit characters from one octet; stops once the char budget runs out
    task automatic septet_chars(input logic [7:0] o, input logic [2:0] kind, input bit in_msg);
        logic [15:0] tmp;
        logic [6:0]  ch;
        tmp = ({8'd0, o} << sep_off) | {9'd0, sep_carry};
        ch = tmp[6:0];
        tmp = {8'd0, o} >> (7 - sep_off);
        sep_carry = tmp[6:0];
        if (chars_to_go != 8'd0) begin
            chars_to_go--;
            add_result(kind, gsm_char(ch), 3'd0, in_msg && chars_to_go == 8'd0);
        end
        // seventh octet completes an extra character from the carry
        if (sep_off == 3'd6) begin
            if (chars_to_go != 8'd0) begin
                chars_to_go--;
                add_result(kind, gsm_char(sep_carry), 3'd0, in_msg && chars_to_go == 8'd0);
            end
            sep_off = 3'd0;
            sep_carry = 7'd0;
        end else begin
            sep_off++;
        end
    endtask

    // Sender length: octet count is half the digit count, rounded up
    task automatic tmp_len(input logic [7:0] o);
        logic [8:0] sum;
        sum = {1'b0, o} + 9'd1;
        left_cnt = sum[8:1];
        chars_to_go = sum[8:1];
        addr_first = 1'b1;
        ps = ST_ADDR_TYPE;
    endtask

    // Expected items for one accepted octet, appended to due_results
    task automatic predict_octet(input logic [7:0] o, input logic start);
        logic [15:0] code;
        bit          have;
        int          i;
        step_n = 0;
        if (start)
            ps = ST_SC_LEN;
        case (ps)
            ST_SC_LEN: begin
                left_cnt = o;
                ps = (o == 8'd0) ? ST_FIRST : ST_SC_SKIP;
            end
            ST_SC_SKIP: begin
                left_cnt--;
                if (left_cnt == 8'd0)
                    ps = ST_FIRST;
            end
            ST_FIRST: ps = ST_ADDR_LEN;
            ST_ADDR_LEN: begin
                tmp_len(o);
            end
            ST_ADDR_TYPE: begin
                alpha_addr = ((o & ALPHA_MASK) == ALPHA_MASK);
                sep_off = 3'd0;
                sep_carry = 7'd0;
                if (!alpha_addr && addr_first)
                    add_result(KIND_SENDER, {8'd0, CHAR_PLUS}, 3'd0, 1'b0);
                addr_first = 1'b0;
                ps = (left_cnt == 8'd0) ? ST_PID : ST_ADDR_DIGITS;
            end
            ST_ADDR_DIGITS: begin
                if (alpha_addr) begin
                    septet_chars(o, KIND_SENDER, 1'b0);
                end else begin
                    // swapped BCD: low nibble first, filler nibble dropped
                    add_result(KIND_SENDER, {12'd0, o[3:0]} + {8'd0, CHAR_ZERO}, 3'd0, 1'b0);
                    if (o[7:4] != BCD_FILLER)
                        add_result(KIND_SENDER, {12'd0, o[7:4]} + {8'd0, CHAR_ZERO},
                                   3'd0, 1'b0);
                end
                left_cnt--;
                if (left_cnt == 8'd0)
                    ps = ST_PID;
            end
            ST_PID: begin
                add_result(KIND_PID, {8'd0, o}, 3'd0, 1'b0);
                ps = ST_DCS;
            end
            ST_DCS: begin
                add_result(KIND_DCS, {8'd0, o}, 3'd0, 1'b0);
                scheme = o[3:0];
                stamp_pos = 3'd0;
                ps = ST_STAMP;
            end
            ST_STAMP: begin
                add_result(KIND_STAMP, {12'd0, o[3:0]} * 16'd10 + {12'd0, o[7:4]},
                           stamp_pos, 1'b0);
                if (stamp_pos == STAMP_LAST) begin
                    stamp_pos = 3'd0;
                    ps = ST_UD_LEN;
                end else begin
                    stamp_pos++;
                end
            end
            ST_UD_LEN: begin
                sep_off = 3'd0;
                sep_carry = 7'd0;
                ucs_hi_valid = 1'b0;
                if (scheme == MODE_GSM7) begin
                    chars_to_go = o;
                    ps = (o == 8'd0) ? ST_IGNORE : ST_UD;
                end else if (scheme == MODE_8BIT || scheme == MODE_UCS2) begin
                    left_cnt = o;
                    ps = (o == 8'd0) ? ST_IGNORE : ST_UD;
                end else begin
                    add_result(KIND_ERROR, {12'd0, scheme}, 3'd0, 1'b1);
                    ps = ST_IGNORE;
                end
            end
            ST_UD: begin
                if (scheme == MODE_GSM7) begin
                    septet_chars(o, KIND_MSG, 1'b1);
                    if (chars_to_go == 8'd0)
                        ps = ST_IGNORE;
                end else if (scheme == MODE_8BIT) begin
                    left_cnt--;
                    add_result(KIND_MSG, {8'd0, o}, 3'd0, left_cnt == 8'd0);
                    if (left_cnt == 8'd0)
                        ps = ST_IGNORE;
                end else begin
                    // UCS-2: big-endian pairs; a lone last octet gets a zero low byte
                    left_cnt--;
                    have = 1'b0;
                    code = 16'd0;
                    if (!ucs_hi_valid) begin
                        ucs_hi = o;
                        ucs_hi_valid = 1'b1;
                        if (left_cnt == 8'd0) begin
                            code = {o, 8'd0};
                            have = 1'b1;
                        end
                    end else begin
                        code = {ucs_hi, o};
                        ucs_hi_valid = 1'b0;
                        have = 1'b1;
                    end
                    if (have) begin
                        if (!wide_mode && (code < NARROW_LO || code > NARROW_HI))
                            code = CHAR_SPACE;
                        add_result(KIND_MSG, code, 3'd0, left_cnt == 8'd0);
                    end
                    if (left_cnt == 8'd0) begin
                        ucs_hi_valid = 1'b0;
                        ps = ST_IGNORE;
                    end
                end
            end
            default: ps = ST_IGNORE;
        endcase
        for (i = 0; i < step_n; i++) begin
            step_buf[i].last = (i == step_n - 1);
            due_results.push_back(step_buf[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: check results, track config writes, predict accepted octets, watchdog
    always @(posedge i_clk) begin
        in_fire = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
        if (!i_rst_n) begin
            ps = ST_SC_LEN;
            left_cnt = 8'd0;
            sep_off = 3'd0;
            sep_carry = 7'd0;
            chars_to_go = 8'd0;
            alpha_addr = 1'b0;
            addr_first = 1'b1;
            scheme = 4'd0;
            ucs_hi = 8'd0;
            ucs_hi_valid = 1'b0;
            stamp_pos = 3'd0;
            wide_mode = 1'b0;
            idle_cycles = 0;
        end else begin
            if (out_fire) begin
                rx_count++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got kind %0d value 0x%0h",
                                 $time, m_axis_tuser, m_axis_tdata[15:0]);
                end else begin
                    want = due_results.pop_front();
                    check_field("item_kind", {13'd0, want.kind}, {13'd0, m_axis_tuser});
                    check_field("item_value", want.value, m_axis_tdata[15:0]);
                    check_field("stamp_index", {13'd0, want.idx}, {13'd0, m_axis_tdata[18:16]});
                    check_field("message_done", {15'd0, want.done}, {15'd0, m_axis_tdata[19]});
                    check_field("last_of_run", {15'd0, want.last}, {15'd0, m_axis_tlast});
                    check_field("tdata pad", 16'd0, {12'd0, m_axis_tdata[23:20]});
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                wide_mode = i_cfg_data;
            if (in_fire)
                predict_octet(s_axis_tdata, s_axis_tuser);
            if (in_fire || out_fire || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("** sms_deliver_pdu_parser: FAILED **");
                $finish;
            end
        end
    end

    // Driver: one octet request per handshake, random gap before each unless no_idle is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = $urandom_range(0, 5);
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (octet_q.size() != 0) begin
                cur_req = octet_q.pop_front();
                s_axis_tdata <= cur_req.octet;
                s_axis_tuser <= cur_req.start;
                s_axis_tvalid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result unless no_idle is set, plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_fire)
                rx_wait = no_idle ? 0 : $urandom_range(0, 5);
            if (rx_count >= long_mark) begin
                rx_wait = LONG_HOLD;
                long_mark += 250;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_octet(input logic [7:0] o, input logic start);
        t_octet_req req;
        req.octet = o;
        req.start = start;
        octet_q.push_back(req);
    endtask

    // Queue one PDU; keep >= 0 cuts it short, trail adds ignored octets after an uncut PDU
    task automatic queue_pdu(input int sca_len, input int digits, input logic [7:0] toa,
                             input logic [7:0] dcs, input int udl, input int keep,
                             input int trail);
        logic [7:0] seq[$];
        logic [7:0] b;
        int         addr_bytes;
        int         body;
        int         i;
        addr_bytes = (digits + 1) / 2;
        case (dcs[3:0])
            MODE_GSM7:            body = (udl * 7 + 7) / 8;
            MODE_8BIT, MODE_UCS2: body = udl;
            default:              body = 0;
        endcase
        seq.push_back(8'(sca_len));
        repeat (sca_len) seq.push_back(8'($urandom));
        seq.push_back(8'($urandom));
        seq.push_back(8'(digits));
        seq.push_back(toa);
        for (i = 0; i < addr_bytes; i++) begin
            b = 8'($urandom);
            if ((toa & ALPHA_MASK) != ALPHA_MASK && digits % 2 == 1 && i == addr_bytes - 1)
                b[7:4] = BCD_FILLER;
            seq.push_back(b);
        end
        seq.push_back(8'($urandom));
        seq.push_back(dcs);
        repeat (7) seq.push_back(8'($urandom));
        seq.push_back(8'(udl));
        for (i = 0; i < body; i++) begin
            b = 8'($urandom);
            // UCS-2 high bytes often zero so narrow-range codes show up
            if (dcs[3:0] == MODE_UCS2 && i % 2 == 0 && $urandom_range(0, 1) == 1)
                b = 8'd0;
            seq.push_back(b);
        end
        for (i = 0; i < seq.size() && (keep < 0 || i < keep); i++) begin
            push_octet(seq[i], i == 0);
            stim_count++;
        end
        if (keep < 0)
            repeat (trail) push_octet(8'($urandom), 1'b0);
    endtask

    // Mostly well-formed PDUs with random content; some cut short, some noise bursts
    task automatic random_batch(input int n);
        int         goal;
        int         pick;
        int         cnt;
        int         sca;
        int         digits;
        int         udl;
        int         keep;
        logic [3:0] mode;
        logic [7:0] toa;
        logic [7:0] dcs;
        goal = stim_count + n;
        while (stim_count < goal) begin
            pdu_serial++;
            pick = $urandom_range(0, 9);
            if (pdu_serial == 2 || pdu_serial == 4)
                pick = 9;
            if (pick == 0) begin
                cnt = $urandom_range(1, 6);
                repeat (cnt) push_octet(8'($urandom), $urandom_range(0, 2) == 0);
                stim_count += cnt;
            end else begin
                sca = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
                digits = $urandom_range(0, 12);
                toa = 8'($urandom);
                if ($urandom_range(0, 9) < 3) begin
                    toa = toa | ALPHA_MASK;
                end else if ((toa & ALPHA_MASK) == ALPHA_MASK) begin
                    case ($urandom_range(0, 2))
                        0:       toa[7] = 1'b0;
                        1:       toa[6] = 1'b0;
                        default: toa[4] = 1'b0;
                    endcase
                end
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: mode = MODE_GSM7;
                    7, 8, 9, 10:         mode = MODE_8BIT;
                    11, 12, 13, 14, 15:  mode = MODE_UCS2;
                    default: begin
                        mode = 4'($urandom_range(0, 15));
                        if (mode == MODE_GSM7 || mode == MODE_8BIT || mode == MODE_UCS2)
                            mode = mode + 4'd1;
                    end
                endcase
                udl = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
                keep = (pick == 1) ? $urandom_range(1, 20) : -1;
                // full-size sender address and a long 7-bit message, once each
                if (pdu_serial == 2) begin
                    digits = 255;
                    toa = 8'hFF;
                    keep = -1;
                end
                if (pdu_serial == 4) begin
                    mode = MODE_GSM7;
                    udl = 120;
                    keep = -1;
                end
                dcs = {4'($urandom), mode};
                queue_pdu(sca, digits, toa, dcs, udl, keep, $urandom_range(0, 2));
            end
        end
    endtask

    // Wait until every request went out and every expected item came back
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (octet_q.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic set_wide(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_wide(1'b0);

        // empty service centre, numeric sender with filler, odd UCS-2 length,
        // narrow mapping, then octets past the end of the message
        queue_pdu(0, 3, 8'h91, {4'h0, MODE_UCS2}, 3, -1, 2);
        wait_quiet();

        set_wide(1'b1);
        random_batch(40);
        wait_quiet();

        set_wide(1'b0);
        no_idle = 1'b1;
        random_batch(40);
        wait_quiet();

        set_wide(1'b1);
        no_idle = 1'b0;
        random_batch(30);
        wait_quiet();

        if (mismatches == 0 && due_results.size() == 0)
            $display("** sms_deliver_pdu_parser: PASSED **");
        else
            $display("** sms_deliver_pdu_parser: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/smsdp_pkg.sv
rtl/smsdp_decode.sv
rtl/sms_deliver_pdu_parser.sv
bench/sms_deliver_pdu_parser_tb.sv
